// ===== rtl/core/dst_pkg.sv =====
// Package: shared types, constants and compare/stencil functions of the depth stencil unit.
package dst_pkg;

  localparam int unsigned BufWidth    = 64;
  localparam int unsigned BufHeight   = 64;
  localparam int unsigned NumSamples  = 4;
  localparam int unsigned Entries     = BufWidth * BufHeight * NumSamples;
  localparam int unsigned AddrW       = $clog2(Entries);
  localparam int unsigned DepthW      = 24;
  localparam int unsigned StencilW    = 8;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 12;
  localparam logic [StencilW-1:0] StencilMax = 8'hFF;

  localparam logic [1:0] OpTest  = 2'd0;
  localparam logic [1:0] OpClear = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;
  // Unused code; behaves as a read.
  localparam logic [1:0] OpSpare = 2'd3;

  localparam logic [CfgIdxW-1:0] RegDepthCtrl  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStEnable   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStReadMask = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStWrMask   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStRef      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegFrontCtrl  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegBackCtrl   = 3'd6;

  localparam logic [2:0] CmpNever = 3'd0, CmpLess = 3'd1, CmpEqual = 3'd2, CmpLessEq = 3'd3,
                         CmpGreater = 3'd4, CmpNotEq = 3'd5, CmpGreaterEq = 3'd6;
  localparam logic [2:0] SopKeep = 3'd0, SopZero = 3'd1, SopReplace = 3'd2, SopIncSat = 3'd3,
                         SopDecSat = 3'd4, SopInvert = 3'd5, SopIncWrap = 3'd6;

  // Classified item handed from front to back.
  typedef struct packed {
    logic                valid_addr;
    logic [1:0]          op;
    logic [AddrW-1:0]    addr;
    logic [DepthW-1:0]   depth;
    logic [StencilW-1:0] clr_stencil;
    logic [11:0]         face_ctrl;
  } cmd_t;

  function automatic logic compare(input logic [2:0] code, input logic [DepthW-1:0] lhs,
                                   input logic [DepthW-1:0] rhs);
    logic r;
    case (code)
      CmpNever:     r = 1'b0;
      CmpLess:      r = lhs < rhs;
      CmpEqual:     r = lhs == rhs;
      CmpLessEq:    r = lhs <= rhs;
      CmpGreater:   r = lhs > rhs;
      CmpNotEq:     r = lhs != rhs;
      CmpGreaterEq: r = lhs >= rhs;
      default:      r = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic [StencilW-1:0] stencil_update(input logic [2:0] code,
      input logic [StencilW-1:0] ref_v, input logic [StencilW-1:0] cur);
    logic [StencilW-1:0] r;
    case (code)
      SopKeep:    r = cur;
      SopZero:    r = '0;
      SopReplace: r = ref_v;
      SopIncSat:  r = (cur == StencilMax) ? cur : cur + 8'd1;
      SopDecSat:  r = (cur == '0) ? cur : cur - 8'd1;
      SopInvert:  r = ~cur;
      SopIncWrap: r = cur + 8'd1;
      default:    r = cur - 8'd1;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/dst_front.sv =====
// Front end: accept an item, decode address and face, push into the command queue.
module dst_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [1:0]        op_i,
  input  logic [5:0]        pos_x_i,
  input  logic [5:0]        pos_y_i,
  input  logic [1:0]        sample_i,
  input  logic [23:0]       depth_i,
  input  logic              front_i,
  input  logic [7:0]        clr_st_i,
  input  logic [11:0]       front_ctrl_i,
  input  logic [11:0]       back_ctrl_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output dst_pkg::cmd_t     cmd_o
);
  // Two-entry queue.
  dst_pkg::cmd_t q_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       push, pop;
  dst_pkg::cmd_t cmd;

  assign s_tready_o = (cnt_q != 2'd2);
  assign push = s_tvalid_i && s_tready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_o = q_q[rd_q];

  always_comb begin
    cmd.valid_addr = (32'(pos_x_i) < dst_pkg::BufWidth) && (32'(pos_y_i) < dst_pkg::BufHeight)
                     && (32'(sample_i) < dst_pkg::NumSamples);
    cmd.op = op_i;
    cmd.addr = dst_pkg::AddrW'((32'(pos_y_i) * dst_pkg::BufWidth + 32'(pos_x_i))
                               * dst_pkg::NumSamples + 32'(sample_i));
    cmd.depth = depth_i;
    cmd.clr_stencil = clr_st_i;
    cmd.face_ctrl = front_i ? front_ctrl_i : back_ctrl_i;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= cmd;
  end
endmodule

// ===== rtl/core/dst_back.sv =====
// Back end: read the sample store, run the tests, write back and emit one result.
module dst_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  dst_pkg::cmd_t     cmd_i,
  input  logic [4:0]        depth_ctrl_i,
  input  logic              st_en_i,
  input  logic [7:0]        st_rmask_i,
  input  logic [7:0]        st_wmask_i,
  input  logic [7:0]        st_ref_i,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [34:0]       res_o
);
  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EXEC, ST_OUT} state_e;
  state_e state_q;

  logic [dst_pkg::DepthW-1:0]   depth_mem [dst_pkg::Entries];
  logic [dst_pkg::StencilW-1:0] st_mem    [dst_pkg::Entries];
  logic [dst_pkg::DepthW-1:0]   rd_d_q;
  logic [dst_pkg::StencilW-1:0] rd_s_q;
  dst_pkg::cmd_t cmd_q;
  logic [34:0] res_q;

  logic dp, stp, sp, wr_d, wr_s;
  logic [2:0] code;
  logic [dst_pkg::DepthW-1:0]   new_d;
  logic [dst_pkg::StencilW-1:0] new_s;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign m_tvalid_o  = (state_q == ST_OUT);
  assign res_o = res_q;

  always_comb begin
    dp = 1'b0; stp = 1'b0; wr_d = 1'b0; wr_s = 1'b0;
    new_d = rd_d_q; new_s = rd_s_q; code = '0;
    if (cmd_q.op == dst_pkg::OpClear) begin
      wr_d = 1'b1; wr_s = 1'b1;
      new_d = cmd_q.depth; new_s = cmd_q.clr_stencil;
    end else if (cmd_q.op == dst_pkg::OpTest) begin
      dp = depth_ctrl_i[0] ? dst_pkg::compare(depth_ctrl_i[3:1], cmd_q.depth, rd_d_q) : 1'b1;
      stp = st_en_i ? dst_pkg::compare(cmd_q.face_ctrl[2:0],
                                        24'(st_ref_i & st_rmask_i),
                                        24'(rd_s_q & st_rmask_i)) : 1'b1;
      if (!stp) code = cmd_q.face_ctrl[5:3];
      else if (!dp) code = cmd_q.face_ctrl[8:6];
      else code = cmd_q.face_ctrl[11:9];
      if (st_en_i) begin
        wr_s = 1'b1;
        new_s = dst_pkg::stencil_update(code, st_ref_i, rd_s_q) & st_wmask_i;
      end
      if (dp && stp && depth_ctrl_i[4]) begin
        wr_d = 1'b1; new_d = cmd_q.depth;
      end
    end
    sp = dp && stp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: if (cmd_valid_i) state_q <= ST_READ;
        ST_READ: state_q <= ST_EXEC;
        ST_EXEC: state_q <= ST_OUT;
        ST_OUT:  if (m_tready_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) cmd_q <= cmd_i;
    if (state_q == ST_READ) begin
      rd_d_q <= depth_mem[cmd_q.addr];
      rd_s_q <= st_mem[cmd_q.addr];
    end
    if (state_q == ST_EXEC) begin
      if (cmd_q.valid_addr) begin
        if (wr_d) depth_mem[cmd_q.addr] <= new_d;
        if (wr_s) st_mem[cmd_q.addr] <= new_s;
        res_q <= {new_s, new_d, stp, dp, sp};
      end else begin
        res_q <= '0;
      end
    end
  end
endmodule

// ===== rtl/core/depth_stencil_test_unit.sv =====
// Top level of the per-sample depth and stencil test unit.
// One fragment sample enters on the s_axis channel and leaves exactly one result on m_axis.
// A front end decodes the sample address and face and queues up to two items; the back end
// handles one item at a time (store read, test and write back, result hold) and takes no
// new item until its result has been taken, so the sustained rate is bounded by the
// single-port read-modify-write of the 16384-entry depth and stencil stores.
// Store contents are undefined after reset; clear a sample before testing or reading it.
// Addresses outside the buffer return an all-zero result and leave the stores alone.
module depth_stencil_test_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: operation[1:0], pos_x[7:2], pos_y[13:8], sample_index[15:14],
  //        fragment_depth[39:16], front_facing[40], clear_stencil_value[48:41], zero pad
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: sample pass[0], depth_ok[1], stencil_ok[2], depth_value[26:3],
  //        stencil_value[34:27], zero pad
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [dst_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dst_pkg::CfgDataW-1:0] cfg_data_i
);
  logic [4:0]  depth_ctrl_q;
  logic        st_en_q;
  logic [7:0]  st_rmask_q, st_wmask_q, st_ref_q;
  logic [11:0] front_ctrl_q, back_ctrl_q;
  logic        cmd_valid, cmd_ready;
  dst_pkg::cmd_t cmd;
  logic [34:0] res;

  // Hold the configuration registers; write them only while the unit is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_ctrl_q <= 5'd19;
      st_en_q      <= 1'b0;
      st_rmask_q   <= 8'hFF;
      st_wmask_q   <= 8'hFF;
      st_ref_q     <= 8'h00;
      front_ctrl_q <= 12'd7;
      back_ctrl_q  <= 12'd7;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dst_pkg::RegDepthCtrl:  depth_ctrl_q <= cfg_data_i[4:0];
        dst_pkg::RegStEnable:   st_en_q      <= cfg_data_i[0];
        dst_pkg::RegStReadMask: st_rmask_q   <= cfg_data_i[7:0];
        dst_pkg::RegStWrMask:   st_wmask_q   <= cfg_data_i[7:0];
        dst_pkg::RegStRef:      st_ref_q     <= cfg_data_i[7:0];
        dst_pkg::RegFrontCtrl:  front_ctrl_q <= cfg_data_i;
        dst_pkg::RegBackCtrl:   back_ctrl_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dst_front u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .op_i        (s_axis_tdata[1:0]),
    .pos_x_i     (s_axis_tdata[7:2]),
    .pos_y_i     (s_axis_tdata[13:8]),
    .sample_i    (s_axis_tdata[15:14]),
    .depth_i     (s_axis_tdata[39:16]),
    .front_i     (s_axis_tdata[40]),
    .clr_st_i    (s_axis_tdata[48:41]),
    .front_ctrl_i(front_ctrl_q),
    .back_ctrl_i (back_ctrl_q),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  dst_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .depth_ctrl_i(depth_ctrl_q),
    .st_en_i     (st_en_q),
    .st_rmask_i  (st_rmask_q),
    .st_wmask_i  (st_wmask_q),
    .st_ref_i    (st_ref_q),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {5'd0, res};
endmodule

// ===== rtl/core/dst_checker.sv =====
// Port-level checker for the depth stencil unit, bound to the top level.
module dst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  // Result must stay while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed under stall");
  // Pad bits are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:35] == 5'd0)
    else $error("pad bits set");
  // Passed implies both tests passed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[0] == (m_axis_tdata[1] && m_axis_tdata[2]))
    else $error("sample_passed inconsistent");
  // No result is offered in the cycle after a result is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("result repeated");
  // Ready is always known while an input is offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid |-> !$isunknown(s_axis_tready))
    else $error("input ready unknown");
endmodule

bind depth_stencil_test_unit dst_checker u_dst_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);

// ===== dv/depth_stencil_test_unit_test.sv =====
// Testbench for the depth stencil test unit: directed table and random traffic vs. a predictor.
`timescale 1ns / 1ps

module depth_stencil_test_unit_test;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned NumRandom     = 950;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [dst_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [dst_pkg::CfgDataW-1:0] cfg_data_i = '0;

  // One fragment sample as it travels on the slave side.
  typedef struct packed {
    logic [dst_pkg::StencilW-1:0] clr_stencil;
    logic                         front;
    logic [dst_pkg::DepthW-1:0]   depth;
    logic [1:0]                   sample;
    logic [5:0]                   y;
    logic [5:0]                   x;
    logic [1:0]                   op;
  } sample_req_t;

  // One result as it travels on the master side.
  typedef struct packed {
    logic [dst_pkg::StencilW-1:0] stencil_value;
    logic [dst_pkg::DepthW-1:0]   depth_value;
    logic                         stencil_ok;
    logic                         depth_ok;
    logic                         sample_passed;
  } test_result_t;

  // Directed row: stimulus, and a typed-in result where one is obvious.
  typedef struct {
    sample_req_t  req;
    logic         has_result;
    test_result_t result;
  } directed_row_t;

  always #5 clk_i = ~clk_i;

  depth_stencil_test_unit i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Shadow of the unit's state.
  logic [dst_pkg::DepthW-1:0]   depth_mem   [dst_pkg::Entries];
  logic [dst_pkg::StencilW-1:0] stencil_mem [dst_pkg::Entries];
  bit                           written     [dst_pkg::Entries];
  logic [4:0]  depth_ctrl;
  logic        st_enable;
  logic [7:0]  st_read_mask, st_write_mask, st_ref;
  logic [11:0] front_ctrl, back_ctrl;

  test_result_t pending_results[$];
  int unsigned  mismatches;
  int unsigned  idle_cycles;
  bit           timed_out;

  function automatic logic depth_cmp(logic [2:0] code, logic [dst_pkg::DepthW-1:0] a,
                                     logic [dst_pkg::DepthW-1:0] b);
    unique case (code)
      dst_pkg::CmpNever:     return 1'b0;
      dst_pkg::CmpLess:      return a < b;
      dst_pkg::CmpEqual:     return a == b;
      dst_pkg::CmpLessEq:    return a <= b;
      dst_pkg::CmpGreater:   return a > b;
      dst_pkg::CmpNotEq:     return a != b;
      dst_pkg::CmpGreaterEq: return a >= b;
      default:               return 1'b1;
    endcase
  endfunction

  function automatic logic [7:0] next_stencil(logic [2:0] code, logic [7:0] cur);
    unique case (code)
      dst_pkg::SopKeep:    return cur;
      dst_pkg::SopZero:    return 8'd0;
      dst_pkg::SopReplace: return st_ref;
      dst_pkg::SopIncSat:  return (cur == 8'hFF) ? cur : cur + 8'd1;
      dst_pkg::SopDecSat:  return (cur == 8'd0) ? cur : cur - 8'd1;
      dst_pkg::SopInvert:  return ~cur;
      dst_pkg::SopIncWrap: return cur + 8'd1;
      default:             return cur - 8'd1;
    endcase
  endfunction

  // Apply one sample to the shadow stores and return the result it produces.
  function automatic test_result_t predict_sample(sample_req_t r);
    test_result_t res;
    int unsigned  a;
    logic [11:0]  face;
    logic         dp, sp;
    logic [2:0]   code;
    res = '0;
    a = ({r.y, r.x} * dst_pkg::NumSamples) + r.sample;
    if (r.op == dst_pkg::OpClear) begin
      depth_mem[a] = r.depth;
      stencil_mem[a] = r.clr_stencil;
      written[a] = 1'b1;
    end else if (r.op == dst_pkg::OpTest) begin
      face = r.front ? front_ctrl : back_ctrl;
      dp = depth_ctrl[0] ? depth_cmp(depth_ctrl[3:1], r.depth, depth_mem[a]) : 1'b1;
      sp = st_enable ? depth_cmp(face[2:0], {16'd0, st_ref & st_read_mask},
                                 {16'd0, stencil_mem[a] & st_read_mask}) : 1'b1;
      res.depth_ok = dp;
      res.stencil_ok = sp;
      res.sample_passed = dp && sp;
      if (st_enable) begin
        code = !sp ? face[5:3] : (!dp ? face[8:6] : face[11:9]);
        stencil_mem[a] = next_stencil(code, stencil_mem[a]) & st_write_mask;
      end
      if (dp && sp && depth_ctrl[4]) depth_mem[a] = r.depth;
    end
    res.depth_value = depth_mem[a];
    res.stencil_value = stencil_mem[a];
    return res;
  endfunction

  task automatic write_reg(logic [dst_pkg::CfgIdxW-1:0] idx,
                           logic [dst_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    unique case (idx)
      dst_pkg::RegDepthCtrl:  depth_ctrl    = val[4:0];
      dst_pkg::RegStEnable:   st_enable     = val[0];
      dst_pkg::RegStReadMask: st_read_mask  = val[7:0];
      dst_pkg::RegStWrMask:   st_write_mask = val[7:0];
      dst_pkg::RegStRef:      st_ref        = val[7:0];
      dst_pkg::RegFrontCtrl:  front_ctrl    = val;
      dst_pkg::RegBackCtrl:   back_ctrl     = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drop the input, drain all outstanding results, then leave some slack.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_all_regs(logic [4:0] dc, logic en, logic [7:0] rm, logic [7:0] wm,
                                logic [7:0] rf, logic [11:0] fc, logic [11:0] bc);
    wait_idle();
    write_reg(dst_pkg::RegDepthCtrl, dst_pkg::CfgDataW'(dc));
    write_reg(dst_pkg::RegStEnable, dst_pkg::CfgDataW'(en));
    write_reg(dst_pkg::RegStReadMask, dst_pkg::CfgDataW'(rm));
    write_reg(dst_pkg::RegStWrMask, dst_pkg::CfgDataW'(wm));
    write_reg(dst_pkg::RegStRef, dst_pkg::CfgDataW'(rf));
    write_reg(dst_pkg::RegFrontCtrl, fc);
    write_reg(dst_pkg::RegBackCtrl, bc);
  endtask

  // Send one sample; the expectation is queued at the transfer edge. The valid line
  // stays high after the transfer unless an idle gap follows.
  task automatic send_sample(sample_req_t r, logic has_result, test_result_t typed);
    test_result_t res;
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, r};
    do @(posedge clk_i); while (!s_axis_tready && !timed_out);
    res = predict_sample(r);
    if (has_result && res != typed) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row mismatch: predictor %h, typed %h", res, typed);
    end
    pending_results.push_back(res);
  endtask

  // Pick an address that has been written, or any address for a clear.
  function automatic sample_req_t random_sample(logic [1:0] op, int unsigned hot);
    sample_req_t r;
    int unsigned a;
    r.op = op;
    r.depth = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'd0)
                                          : 24'($urandom);
    r.front = 1'($urandom_range(0, 1));
    r.clr_stencil = 8'($urandom);
    do begin
      r.x = (hot != 0) ? 6'($urandom_range(0, 3)) : 6'($urandom);
      r.y = (hot != 0) ? 6'($urandom_range(0, 1)) : 6'($urandom);
      r.sample = 2'($urandom_range(0, 3));
      a = ({r.y, r.x} * dst_pkg::NumSamples) + r.sample;
    end while (op != dst_pkg::OpClear && !written[a]);
    return r;
  endfunction

  directed_row_t dir_table[$];

  task automatic add_row(logic [1:0] op, logic [5:0] x, logic [5:0] y, logic [1:0] s,
                         logic [23:0] d, logic f, logic [7:0] cs, logic typed,
                         test_result_t res);
    directed_row_t row;
    row.req = '{clr_stencil: cs, front: f, depth: d, sample: s, y: y, x: x, op: op};
    row.has_result = typed;
    row.result = res;
    dir_table.push_back(row);
  endtask

  // Check results on the master side; the ready line stalls at random.
  initial begin
    int unsigned stall;
    test_result_t got, want;
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = m_axis_tdata[34:0];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: sp %0b/%0b dp %0b/%0b stp %0b/%0b depth %h/%h st %h/%h",
                     want.sample_passed, got.sample_passed, want.depth_ok,
                     got.depth_ok, want.stencil_ok, got.stencil_ok,
                     want.depth_value, got.depth_value, want.stencil_value,
                     got.stencil_value);
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer or configuration write, and stop at the limit.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else if (idle_cycles >= WatchdogLimit) begin
      timed_out <= 1'b1;
      $display("depth_stencil_test_unit verification failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    logic [2:0] c;
    int unsigned phase, kind;
    test_result_t z;
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    foreach (written[i]) written[i] = 1'b0;
    depth_ctrl = 5'd19; st_enable = 1'b0; st_read_mask = 8'hFF; st_write_mask = 8'hFF;
    st_ref = 8'd0; front_ctrl = 12'd7; back_ctrl = 12'd7;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows at reset settings: clears, reads, extremes, out of range is not possible
    // with 64x64x4 and 6/6/2-bit fields, so every address is legal.
    z = '0;
    add_row(dst_pkg::OpClear, 6'd0, 6'd0, 2'd0, 24'hFFFFFF, 1'b1, 8'hFF, 1'b1,
            '{8'hFF, 24'hFFFFFF, 1'b0, 1'b0, 1'b0});
    add_row(dst_pkg::OpRead, 6'd0, 6'd0, 2'd0, 24'd0, 1'b0, 8'd0, 1'b1,
            '{8'hFF, 24'hFFFFFF, 1'b0, 1'b0, 1'b0});
    add_row(dst_pkg::OpClear, 6'd63, 6'd63, 2'd3, 24'd0, 1'b0, 8'd0, 1'b1, z);
    add_row(dst_pkg::OpSpare, 6'd63, 6'd63, 2'd3, 24'hABCDEF, 1'b1, 8'h55, 1'b1, z);
    // Reset depth compare is less with write on: smaller passes and is written.
    add_row(dst_pkg::OpTest, 6'd0, 6'd0, 2'd0, 24'h000001, 1'b1, 8'd0, 1'b1,
            '{8'hFF, 24'h000001, 1'b1, 1'b1, 1'b1});
    add_row(dst_pkg::OpTest, 6'd0, 6'd0, 2'd0, 24'hFFFFFF, 1'b0, 8'd0, 1'b1,
            '{8'hFF, 24'h000001, 1'b1, 1'b0, 1'b0});
    add_row(dst_pkg::OpTest, 6'd63, 6'd63, 2'd3, 24'd0, 1'b1, 8'd0, 1'b1,
            '{8'h00, 24'd0, 1'b1, 1'b0, 1'b0});
    add_row(dst_pkg::OpClear, 6'd5, 6'd9, 2'd1, 24'h800000, 1'b1, 8'h80, 1'b0, z);
    add_row(dst_pkg::OpTest, 6'd5, 6'd9, 2'd1, 24'h7FFFFF, 1'b0, 8'h12, 1'b0, z);
    foreach (dir_table[i]) send_sample(dir_table[i].req, dir_table[i].has_result,
                                       dir_table[i].result);

    // Stencil on: every compare and every stencil op on both faces, hot spot addresses.
    for (int unsigned k = 0; k < 8; k++) begin
      c = k[2:0];
      write_all_regs({1'b1, c, 1'b1}, 1'b1, 8'hF0, 8'hFF, 8'h80,
                     {c, c + 3'd1, c + 3'd2, c}, {c + 3'd3, c, c + 3'd5, c + 3'd6});
      send_sample(random_sample(dst_pkg::OpClear, 1), 1'b0, z);
      send_sample(random_sample(dst_pkg::OpTest, 1), 1'b0, z);
      send_sample(random_sample(dst_pkg::OpTest, 1), 1'b0, z);
    end

    // Random phases with fresh settings, extremes included at the ends.
    for (phase = 0; phase < 12 && !timed_out; phase++) begin
      if (phase == 0) write_all_regs(5'd0, 1'b0, 8'h00, 8'h00, 8'h00, 12'h000, 12'h000);
      else if (phase == 11)
        write_all_regs(5'h1F, 1'b1, 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF);
      else
        write_all_regs(5'($urandom), $urandom_range(0, 3) != 0, 8'($urandom), 8'($urandom),
                       8'($urandom), 12'($urandom), 12'($urandom));
      for (int unsigned n = 0; n < NumRandom / 12; n++) begin
        kind = $urandom_range(0, 9);
        if (kind < 2)
          send_sample(random_sample(dst_pkg::OpClear, $urandom_range(0, 1)), 1'b0, z);
        else if (kind < 3)
          send_sample(random_sample(($urandom_range(0, 1) != 0) ? dst_pkg::OpRead
                                                                 : dst_pkg::OpSpare, 1),
                      1'b0, z);
        else
          send_sample(random_sample(dst_pkg::OpTest, ($urandom_range(0, 3) != 0) ? 1 : 0),
                      1'b0, z);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("depth_stencil_test_unit verification clean");
    else
      $display("depth_stencil_test_unit verification failed");
    $finish;
  end

endmodule
